// ===== src/irb_pkg.sv =====
// package for the bilinear image rotator
// holds the item structs, register indexes and the item kind codes
// no dependencies
package irb_pkg;

	typedef struct packed {
		logic       kind;
		logic [9:0] pos_x;
		logic [9:0] pos_y;
		logic [7:0] pix_red;
		logic [7:0] pix_green;
		logic [7:0] pix_blue;
		logic [7:0] pix_alpha;
	} in_item_t;

	typedef struct packed {
		logic [9:0] res_x;
		logic [9:0] res_y;
		logic [7:0] res_red;
		logic [7:0] res_green;
		logic [7:0] res_blue;
		logic [7:0] res_alpha;
	} out_item_t;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_COMPUTE = 1'b1;

	localparam logic [2:0] REG_COS  = 3'd0;
	localparam logic [2:0] REG_SIN  = 3'd1;
	localparam logic [2:0] REG_SCOL = 3'd2;
	localparam logic [2:0] REG_SROW = 3'd3;
	localparam logic [2:0] REG_DCOL = 3'd4;
	localparam logic [2:0] REG_DROW = 3'd5;
	localparam logic [2:0] REG_BG   = 3'd6;
	localparam logic [2:0] REG_MODE = 3'd7;

endpackage

// ===== src/irb_ram.sv =====
// generic single-port-write, one-port-read RAM with registered read data
// no dependencies
module irb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== src/image_rotate_bilinear.sv =====
// Image rotator with bilinear or nearest-neighbor sampling: top level.
// Depends on irb_pkg and irb_ram.
//
// Load items write source pixels (composited if the background is opaque);
// compute items give one rotated pixel each. The pipeline takes one item
// every cycle: stage 1 forms the products, stage 2 the source position and
// bank addresses, stage 3 is the RAM read and edge masking, stages 4 and 5
// the two interpolation passes, then a result register. The pixel store is
// four RAMs banked by row and column parity, so the four neighbors come out
// in one read. The whole pipeline holds, and the input stalls, only while a
// result waits in the output register. A load writes as it leaves stage 2,
// before the compute behind it reads, so a compute that follows a load
// always sees it. The store has no reset pass.
module image_rotate_bilinear #(
	parameter int MAX_SRC_WIDTH  = 256,
	parameter int MAX_SRC_HEIGHT = 256,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  irb_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output irb_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	localparam int FB  = TRIG_FRAC_BITS + 1;
	localparam int XW  = (MAX_SRC_WIDTH > 2) ? $clog2(MAX_SRC_WIDTH) : 2;
	localparam int YW  = (MAX_SRC_HEIGHT > 2) ? $clog2(MAX_SRC_HEIGHT) : 2;
	localparam int BXW = XW - 1;
	localparam int BYW = YW - 1;
	localparam int BAW = BXW + BYW;
	localparam int BDEPTH = 1 << BAW;
	localparam int PW  = 16 + 12 + 1;
	localparam int SW  = (PW + 2 > FB + 14) ? PW + 2 : FB + 14;
	localparam int IW  = SW - FB;
	localparam int WW  = FB + 1;

	// configuration registers
	logic [14:0] cos_q;
	logic [15:0] sin_q;
	logic [8:0]  scol_q, srow_q;
	logic [9:0]  dcol_q, drow_q;
	logic [31:0] bg_q;
	logic        mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q  <= 15'd16384;
			sin_q  <= '0;
			scol_q <= 9'd256;
			srow_q <= 9'd256;
			dcol_q <= 10'd256;
			drow_q <= 10'd256;
			bg_q   <= '0;
			mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				irb_pkg::REG_COS:  cos_q  <= cfg_data[14:0];
				irb_pkg::REG_SIN:  sin_q  <= cfg_data[15:0];
				irb_pkg::REG_SCOL: scol_q <= cfg_data[8:0];
				irb_pkg::REG_SROW: srow_q <= cfg_data[8:0];
				irb_pkg::REG_DCOL: dcol_q <= cfg_data[9:0];
				irb_pkg::REG_DROW: drow_q <= cfg_data[9:0];
				irb_pkg::REG_BG:   bg_q   <= cfg_data;
				irb_pkg::REG_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pipeline advance: a full output register that is stalled holds everything
	logic adv;
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: center offsets and the four trig products
	logic                 k1_s1;
	logic [9:0]           x1_s1, y1_s1;
	logic [31:0]          c1_s1;
	logic signed [PW-1:0] cdx_s1, sdy_s1, sdx_s1, cdy_s1;
	logic signed [11:0]   dx, dy;
	logic signed [16:0]   cs, sn;
	assign dx = $signed({1'b0, in_data.pos_x, 1'b0}) - $signed({2'b0, dcol_q});
	assign dy = $signed({1'b0, in_data.pos_y, 1'b0}) - $signed({2'b0, drow_q});
	assign cs = $signed({2'b0, cos_q});
	assign sn = $signed({sin_q[15], sin_q});

	// compositing over an opaque background
	function automatic logic [7:0] comp(input logic [7:0] c, input logic [7:0] b,
			input logic [7:0] a);
		logic [16:0] t;
		logic [8:0]  v;
		t = 17'(b * (8'hff - a)) + 17'd128;
		t = (t + (t >> 8)) >> 8;
		v = 9'(c) + t[8:0];
		return v[8] ? 8'hff : v[7:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v1_s1 <= 1'b0;
		else if (adv) v1_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k1_s1  <= in_data.kind;
			x1_s1  <= in_data.pos_x;
			y1_s1  <= in_data.pos_y;
			cdx_s1 <= PW'(cs * dx);
			sdy_s1 <= PW'(sn * dy);
			sdx_s1 <= PW'(sn * dx);
			cdy_s1 <= PW'(cs * dy);
			if (bg_q[7:0] == 8'hff)
				c1_s1 <= {comp(in_data.pix_red, bg_q[31:24], in_data.pix_alpha),
					comp(in_data.pix_green, bg_q[23:16], in_data.pix_alpha),
					comp(in_data.pix_blue, bg_q[15:8], in_data.pix_alpha), 8'hff};
			else
				c1_s1 <= {in_data.pix_red, in_data.pix_green, in_data.pix_blue,
					in_data.pix_alpha};
		end
	end

	// stage 2: source position, neighbors and bank addresses
	logic signed [SW-1:0] sx, sy, sxr, syr;
	logic signed [IW-1:0] x0, y0;
	logic [FB-1:0]        fx, fy;
	assign sx  = SW'(cdx_s1) - SW'(sdy_s1) + $signed({{(SW-9-TRIG_FRAC_BITS){1'b0}},
		scol_q, {TRIG_FRAC_BITS{1'b0}}});
	assign sy  = SW'(sdx_s1) + SW'(cdy_s1) + $signed({{(SW-9-TRIG_FRAC_BITS){1'b0}},
		srow_q, {TRIG_FRAC_BITS{1'b0}}});
	assign sxr = mode_q ? sx : sx + SW'(1 << TRIG_FRAC_BITS);
	assign syr = mode_q ? sy : sy + SW'(1 << TRIG_FRAC_BITS);
	assign x0  = sxr[SW-1:FB];
	assign y0  = syr[SW-1:FB];
	assign fx  = sx[FB-1:0];
	assign fy  = sy[FB-1:0];

	// in-range test for one neighbor coordinate
	function automatic logic inb(input logic signed [IW:0] p, input logic [8:0] lim,
			input int maxv);
		return (p >= 0) && (p < $signed({{(IW-8){1'b0}}, lim})) && (p < maxv);
	endfunction

	logic signed [IW:0] xa, xb, ya, yb;
	assign xa = {x0[IW-1], x0};
	assign xb = xa + $signed((IW+1)'(1));
	assign ya = {y0[IW-1], y0};
	assign yb = ya + $signed((IW+1)'(1));

	// bank (px,py) holds columns of parity px and rows of parity py
	logic [BXW-1:0] bx [2];
	logic [BYW-1:0] by [2];
	logic [3:0]     in2;
	always_comb begin
		bx[0] = x0[0] ? xb[XW-1:1] : xa[XW-1:1];
		bx[1] = x0[0] ? xa[XW-1:1] : xb[XW-1:1];
		by[0] = y0[0] ? yb[YW-1:1] : ya[YW-1:1];
		by[1] = y0[0] ? ya[YW-1:1] : yb[YW-1:1];
		in2[0] = inb(xa, scol_q, MAX_SRC_WIDTH) && inb(ya, srow_q, MAX_SRC_HEIGHT);
		in2[1] = inb(xb, scol_q, MAX_SRC_WIDTH) && inb(ya, srow_q, MAX_SRC_HEIGHT);
		in2[2] = inb(xa, scol_q, MAX_SRC_WIDTH) && inb(yb, srow_q, MAX_SRC_HEIGHT);
		in2[3] = inb(xb, scol_q, MAX_SRC_WIDTH) && inb(yb, srow_q, MAX_SRC_HEIGHT);
	end

	// load position widened to the store address bits
	logic [XW+9:0] lx;
	logic [YW+9:0] ly;
	assign lx = (XW+10)'(x1_s1);
	assign ly = (YW+10)'(y1_s1);

	logic          k2_s2, px_s2, py_s2, ld_s2;
	logic [9:0]    x2_s2, y2_s2;
	logic [31:0]   c2_s2;
	logic [3:0]    in_s2;
	logic [FB-1:0] fx_s2, fy_s2;
	logic [BAW-1:0] ra_s2 [4];
	logic [BAW-1:0] wa_s2;
	logic [1:0]    wb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v2_s2 <= 1'b0;
		else if (adv) v2_s2 <= v1_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k2_s2 <= k1_s1;
			x2_s2 <= x1_s1;
			y2_s2 <= y1_s1;
			c2_s2 <= c1_s1;
			in_s2 <= in2;
			fx_s2 <= mode_q ? fx : '0;
			fy_s2 <= mode_q ? fy : '0;
			px_s2 <= x0[0];
			py_s2 <= y0[0];
			for (int b = 0; b < 4; b++)
				ra_s2[b] <= {by[b>>1], bx[b&1]};
			ld_s2 <= (x1_s1 < MAX_SRC_WIDTH) && (y1_s1 < MAX_SRC_HEIGHT);
			wa_s2 <= {ly[YW-1:1], lx[XW-1:1]};
			wb_s2 <= {y1_s1[0], x1_s1[0]};
		end
	end

	// hold read address while stalled so read data stays valid
	logic [BAW-1:0] ra_q [4];
	always_ff @(posedge clk) begin
		if (adv) for (int b = 0; b < 4; b++) ra_q[b] <= ra_s2[b];
	end

	// four banked stores: reads issue from stage 2, loads write from stage 2
	logic [31:0] rd [4];
	logic        wr;
	assign wr = adv && v2_s2 && (k2_s2 == irb_pkg::KIND_LOAD) && ld_s2;
	for (genvar b = 0; b < 4; b++) begin : g_bank
		irb_ram #(.WIDTH(32), .DEPTH(BDEPTH)) u_ram (
			.clk   (clk),
			.we    (wr && (wb_s2 == 2'(b))),
			.waddr (wa_s2),
			.wdata (c2_s2),
			.raddr (adv ? ra_s2[b] : ra_q[b]),
			.rdata (rd[b])
		);
	end

	// forward a load written in the same cycle as the read of that entry
	logic        fwd_v_q;
	logic [1:0]  fwd_b_q;
	logic [BAW-1:0] fwd_a_q;
	logic [31:0] fwd_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fwd_v_q <= 1'b0;
		else if (adv) fwd_v_q <= wr;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_b_q <= wb_s2;
			fwd_a_q <= wa_s2;
			fwd_d_q <= c2_s2;
		end
	end

	// stage 3: pick neighbors from banks, mask out-of-range as background
	logic          k3_s3;
	logic [9:0]    x3_s3, y3_s3;
	logic [3:0]    in_s3;
	logic          px_s3, py_s3;
	logic [FB-1:0] fx_s3, fy_s3;
	logic [BAW-1:0] ra3_s3 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v3_s3 <= 1'b0;
		else if (adv) v3_s3 <= v2_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			k3_s3 <= k2_s2;
			x3_s3 <= x2_s2;
			y3_s3 <= y2_s2;
			in_s3 <= in_s2;
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			for (int b = 0; b < 4; b++) ra3_s3[b] <= ra_s2[b];
		end
	end

	logic [31:0] bk [4];
	logic [31:0] nb [4];
	always_comb begin
		for (int b = 0; b < 4; b++)
			bk[b] = (fwd_v_q && fwd_b_q == 2'(b) && fwd_a_q == ra3_s3[b]) ? fwd_d_q
				: rd[b];
		for (int n = 0; n < 4; n++) begin
			nb[n] = bk[{(py_s3 ^ n[1]), (px_s3 ^ n[0])}];
			if (!in_s3[n]) nb[n] = bg_q;
		end
	end

	// stage 4: horizontal pass per channel
	logic [WW+7:0] top_s4 [4];
	logic [WW+7:0] bot_s4 [4];
	logic          k4_s4;
	logic [9:0]    x4_s4, y4_s4;
	logic [FB-1:0] fy_s4;
	logic [WW-1:0] wfx;
	assign wfx = WW'(1 << FB) - WW'(fx_s3);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v4_s4 <= 1'b0;
		else if (adv) v4_s4 <= v3_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			k4_s4 <= k3_s3;
			x4_s4 <= x3_s3;
			y4_s4 <= y3_s3;
			fy_s4 <= fy_s3;
			for (int k = 0; k < 4; k++) begin
				top_s4[k] <= (WW+8)'(wfx * nb[0][31-8*k -: 8]) +
					(WW+8)'(fx_s3 * nb[1][31-8*k -: 8]);
				bot_s4[k] <= (WW+8)'(wfx * nb[2][31-8*k -: 8]) +
					(WW+8)'(fx_s3 * nb[3][31-8*k -: 8]);
			end
		end
	end

	// stage 5: vertical pass, shift and clamp
	logic [7:0]   ch_s5 [4];
	logic         k5_s5;
	logic [9:0]   x5_s5, y5_s5;
	logic [WW-1:0] wfy;
	logic [2*WW+7:0] acc [4];
	assign wfy = WW'(1 << FB) - WW'(fy_s4);
	always_comb begin
		for (int k = 0; k < 4; k++)
			acc[k] = (2*WW+8)'(wfy * top_s4[k]) + (2*WW+8)'(fy_s4 * bot_s4[k]);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v5_s5 <= 1'b0;
		else if (adv) v5_s5 <= v4_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			k5_s5 <= k4_s4;
			x5_s5 <= x4_s4;
			y5_s5 <= y4_s4;
			for (int k = 0; k < 4; k++)
				ch_s5[k] <= (acc[k][2*WW+7:2*FB] > 255) ? 8'hff : acc[k][2*FB+7:2*FB];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v5_s5 && (k5_s5 == irb_pkg::KIND_COMPUTE);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.res_x     <= x5_s5;
			out_data.res_y     <= y5_s5;
			out_data.res_red   <= ch_s5[0];
			out_data.res_green <= ch_s5[1];
			out_data.res_blue  <= ch_s5[2];
			out_data.res_alpha <= ch_s5[3];
		end
	end
endmodule

// ===== bench/image_rotate_bilinear_tb.sv =====
// testbench for the bilinear image rotator: drives load and compute items,
// predicts every rotated pixel and checks each result item field by field
// depends on irb_pkg and image_rotate_bilinear
`timescale 1ns / 1ps

module image_rotate_bilinear_tb;

	localparam int STORE_W = 256;
	localparam int STORE_H = 256;
	localparam int FRAC    = 15;
	localparam int IDLE_LIMIT = 20000;
	localparam int IN_W = $bits(irb_pkg::in_item_t);
	localparam logic [31:0] DIR_BG = 32'h11223344;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	irb_pkg::in_item_t   in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	irb_pkg::out_item_t  out_data;
	logic                cfg_we = 1'b0;
	logic [2:0]          cfg_index = irb_pkg::REG_COS;
	logic [31:0]         cfg_data = '0;

	// rotator state as the bench sees it
	logic [31:0] pixel_store [STORE_W*STORE_H];
	bit          was_loaded  [STORE_W*STORE_H];
	logic [14:0] cur_cos;
	logic [15:0] cur_sin;
	logic [8:0]  cur_scols, cur_srows;
	logic [9:0]  cur_dcols, cur_drows;
	logic [31:0] cur_bg;
	logic        cur_bilinear;

	irb_pkg::out_item_t pending_pixels[$];
	int          fail_count = 0;
	int          idle_cycles = 0;
	bit          hold_req = 1'b0;
	bit          calm = 1'b0;

	typedef struct {
		irb_pkg::in_item_t  item;
		bit                 typed;
		irb_pkg::out_item_t want;
	} step_t;

	image_rotate_bilinear dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// porter-duff over an opaque background, rounded divide by 255
	function automatic logic [31:0] blend_alpha(logic [31:0] c, logic [31:0] a);
		logic [31:0] t;
		t = c * a + 32'd128;
		return (t + (t >> 8)) >> 8;
	endfunction

	function automatic logic [31:0] sample_at(longint x, longint y);
		if (x < 0 || y < 0 || x >= cur_scols || y >= cur_srows ||
			x >= STORE_W || y >= STORE_H)
			return cur_bg;
		return pixel_store[y*STORE_W + x];
	endfunction

	// update the store for a load, or work out the rotated pixel for a compute
	function automatic bit rotate_pixel(irb_pkg::in_item_t it,
			output irb_pkg::out_item_t r);
		longint sx, sy, dx, dy, cs, sn, x0, y0, fx, fy, top, bot, v;
		longint w;
		logic [31:0] p00, p01, p10, p11, word;
		logic [7:0] ch [4];
		w = 64'sd1 << FRAC;
		r = '0;
		if (it.kind == irb_pkg::KIND_LOAD) begin
			if (it.pos_x >= STORE_W || it.pos_y >= STORE_H)
				return 1'b0;
			word = {it.pix_red, it.pix_green, it.pix_blue, it.pix_alpha};
			if (cur_bg[7:0] == 8'hff) begin
				for (int k = 0; k < 3; k++) begin
					v = longint'(word[31-8*k -: 8]) + longint'(blend_alpha(
						32'(cur_bg[31-8*k -: 8]), 32'd255 - 32'(it.pix_alpha)));
					word[31-8*k -: 8] = (v > 255) ? 8'hff : v[7:0];
				end
				word[7:0] = 8'hff;
			end
			pixel_store[it.pos_y*STORE_W + it.pos_x] = word;
			was_loaded[it.pos_y*STORE_W + it.pos_x] = 1'b1;
			return 1'b0;
		end
		cs = cur_cos;
		sn = $signed(cur_sin);
		dx = 2 * longint'(it.pos_x) - cur_dcols;
		dy = 2 * longint'(it.pos_y) - cur_drows;
		sx = cs*dx - sn*dy + (longint'(cur_scols) << (FRAC-1));
		sy = sn*dx + cs*dy + (longint'(cur_srows) << (FRAC-1));
		if (cur_bilinear) begin
			x0 = sx >>> FRAC;
			y0 = sy >>> FRAC;
			fx = sx & (w - 1);
			fy = sy & (w - 1);
			p00 = sample_at(x0, y0);
			p01 = sample_at(x0 + 1, y0);
			p10 = sample_at(x0, y0 + 1);
			p11 = sample_at(x0 + 1, y0 + 1);
			for (int k = 0; k < 4; k++) begin
				top = (w-fx)*p00[31-8*k -: 8] + fx*p01[31-8*k -: 8];
				bot = (w-fx)*p10[31-8*k -: 8] + fx*p11[31-8*k -: 8];
				v = ((w-fy)*top + fy*bot) >> (2*FRAC);
				ch[k] = (v > 255) ? 8'hff : v[7:0];
			end
		end else begin
			p00 = sample_at((sx + (w >> 1)) >>> FRAC, (sy + (w >> 1)) >>> FRAC);
			for (int k = 0; k < 4; k++)
				ch[k] = p00[31-8*k -: 8];
		end
		r = {it.pos_x, it.pos_y, ch[0], ch[1], ch[2], ch[3]};
		return 1'b1;
	endfunction

	// mostly short gaps, a few long, none while calm
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic offer_item(irb_pkg::in_item_t it, bit typed, irb_pkg::out_item_t want,
			bit no_gap);
		int gap;
		irb_pkg::out_item_t r;
		gap = no_gap ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (rotate_pixel(it, r))
			pending_pixels.push_back(typed ? want : r);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			irb_pkg::REG_COS:  cur_cos = val[14:0];
			irb_pkg::REG_SIN:  cur_sin = val[15:0];
			irb_pkg::REG_SCOL: cur_scols = val[8:0];
			irb_pkg::REG_SROW: cur_srows = val[8:0];
			irb_pkg::REG_DCOL: cur_dcols = val[9:0];
			irb_pkg::REG_DROW: cur_drows = val[9:0];
			irb_pkg::REG_BG:   cur_bg = val;
			default:           cur_bilinear = val[0];
		endcase
	endtask

	// wait for every result, then let trailing loads leave the pipeline
	task automatic wait_idle();
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// every in-bounds entry of the source region gets loaded before reads
	task automatic fill_region();
		irb_pkg::in_item_t it;
		for (int y = 0; y < cur_srows && y < STORE_H; y++)
			for (int x = 0; x < cur_scols && x < STORE_W; x++)
				if (!was_loaded[y*STORE_W + x]) begin
					it = {irb_pkg::KIND_LOAD, 10'(x), 10'(y), 32'($urandom())};
					offer_item(it, 1'b0, '0, 1'b1);
				end
	endtask

	task automatic random_items(int n);
		irb_pkg::in_item_t it;
		int xr, yr;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 49) == 0) calm = ~calm;
			it = irb_pkg::in_item_t'(IN_W'({$urandom(), $urandom()}));
			xr = (cur_scols > STORE_W) ? STORE_W : int'(cur_scols);
			yr = (cur_srows > STORE_H) ? STORE_H : int'(cur_srows);
			if ($urandom_range(0, 99) < 60) begin
				it.kind = irb_pkg::KIND_COMPUTE;
				if ($urandom_range(0, 3) != 0) begin
					it.pos_x = 10'($urandom_range(0, cur_dcols));
					it.pos_y = 10'($urandom_range(0, cur_drows));
				end
			end else begin
				it.kind = irb_pkg::KIND_LOAD;
				if (xr > 0 && yr > 0 && $urandom_range(0, 3) != 0) begin
					it.pos_x = 10'($urandom_range(0, xr - 1));
					it.pos_y = 10'($urandom_range(0, yr - 1));
				end
				if ($urandom_range(0, 3) == 0)
					it.pix_alpha = $urandom_range(0, 1) ? 8'hff : 8'h00;
			end
			offer_item(it, 1'b0, '0, 1'b0);
		end
		calm = 1'b0;
	endtask

	task automatic run_setting(logic [14:0] c, logic [15:0] s, logic [8:0] sc,
			logic [8:0] sr, logic [9:0] dc, logic [9:0] dr, logic [31:0] bg,
			logic m, int n);
		wait_idle();
		write_reg(irb_pkg::REG_COS, 32'(c));
		write_reg(irb_pkg::REG_SIN, 32'(s));
		write_reg(irb_pkg::REG_SCOL, 32'(sc));
		write_reg(irb_pkg::REG_SROW, 32'(sr));
		write_reg(irb_pkg::REG_DCOL, 32'(dc));
		write_reg(irb_pkg::REG_DROW, 32'(dr));
		write_reg(irb_pkg::REG_BG, bg);
		write_reg(irb_pkg::REG_MODE, 32'(m));
		fill_region();
		random_items(n);
	endtask

	function automatic step_t mk_step(logic kind, int x, int y, logic [31:0] rgba,
			bit typed);
		step_t st;
		st.item = {kind, 10'(x), 10'(y), rgba};
		st.typed = typed;
		st.want = {10'(x), 10'(y), DIR_BG};
		return st;
	endfunction

	// result checker
	always @(posedge clk) begin
		irb_pkg::out_item_t want;
		if (out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				$display("%t: unexpected pixel %h", $realtime, out_data);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (out_data.res_x !== want.res_x || out_data.res_y !== want.res_y ||
					out_data.res_red !== want.res_red ||
					out_data.res_green !== want.res_green ||
					out_data.res_blue !== want.res_blue ||
					out_data.res_alpha !== want.res_alpha) begin
					$display("%t: pixel mismatch expected %h actual %h",
						$realtime, want, out_data);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no item accepted anywhere
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver back-pressure, with one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (300) @(negedge clk);
				out_stall = 1'b0;
				hold_req = 1'b0;
			end else if (calm) begin
				out_stall = 1'b0;
			end else if ($urandom_range(0, 99) < 3) begin
				out_stall = 1'b1;
				repeat ($urandom_range(10, 40)) @(negedge clk);
				out_stall = 1'b0;
			end else begin
				out_stall = ($urandom_range(0, 99) < 25);
			end
		end
	end

	initial begin
		step_t steps[$];
		cur_cos = 15'd16384; cur_sin = '0; cur_scols = 9'd256; cur_srows = 9'd256;
		cur_dcols = 10'd256; cur_drows = 10'd256; cur_bg = '0; cur_bilinear = 1'b1;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty source: every compute reads the background
		write_reg(irb_pkg::REG_SCOL, 32'd0);
		write_reg(irb_pkg::REG_SROW, 32'd0);
		write_reg(irb_pkg::REG_BG, DIR_BG);
		steps.push_back(mk_step(irb_pkg::KIND_COMPUTE, 0, 0, 32'h0, 1'b1));
		steps.push_back(mk_step(irb_pkg::KIND_COMPUTE, 1023, 1023, 32'h0, 1'b1));
		steps.push_back(mk_step(irb_pkg::KIND_COMPUTE, 1023, 0, 32'h0, 1'b1));
		steps.push_back(mk_step(irb_pkg::KIND_COMPUTE, 0, 1023, 32'h0, 1'b1));
		steps.push_back(mk_step(irb_pkg::KIND_COMPUTE, 128, 128, 32'h0, 1'b1));
		// loads at store corners, and ones beyond the store that are dropped
		steps.push_back(mk_step(irb_pkg::KIND_LOAD, 0, 0, 32'h00000000, 1'b0));
		steps.push_back(mk_step(irb_pkg::KIND_LOAD, 255, 255, 32'hffffffff, 1'b0));
		steps.push_back(mk_step(irb_pkg::KIND_LOAD, 1023, 0, 32'h12345678, 1'b0));
		steps.push_back(mk_step(irb_pkg::KIND_LOAD, 0, 1023, 32'h87654321, 1'b0));
		steps.push_back(mk_step(irb_pkg::KIND_LOAD, 256, 256, 32'haa55aa55, 1'b0));
		steps.push_back(mk_step(irb_pkg::KIND_LOAD, 255, 0, 32'h55aa55aa, 1'b0));
		steps.push_back(mk_step(irb_pkg::KIND_LOAD, 0, 255, 32'hff00ff00, 1'b0));
		steps.push_back(mk_step(irb_pkg::KIND_COMPUTE, 0, 0, 32'h0, 1'b0));
		steps.push_back(mk_step(irb_pkg::KIND_COMPUTE, 255, 255, 32'h0, 1'b0));
		for (int i = 0; i < steps.size(); i++)
			offer_item(steps[i].item, steps[i].typed, steps[i].want, 1'b0);

		// identity, small image, bilinear sampling
		run_setting(15'd16384, 16'd0, 9'd4, 9'd4, 10'd4, 10'd4, 32'h0, 1'b1, 30);
		// receiver holds off while items keep coming
		hold_req = 1'b1;
		run_setting(15'd11585, 16'd11585, 9'd8, 9'd6, 10'd12, 10'd12,
			32'h8040c0ff, 1'b1, 60);
		// opaque white background makes composited channels saturate
		run_setting(15'd0, 16'hc000, 9'd1, 9'd1, 10'd1, 10'd1, 32'hffffffff, 1'b0, 30);
		run_setting(15'd32767, 16'h8000, 9'd16, 9'd3, 10'd1023, 10'd1023,
			32'h00000000, 1'b1, 40);
		run_setting(15'd0, 16'd16384, 9'd5, 9'd9, 10'd9, 10'd5, 32'h102030ff, 1'b0, 40);
		// full store width, one row deep
		run_setting(15'd14189, 16'he000, 9'd256, 9'd1, 10'd350, 10'd350,
			32'h0a0b0c0d, 1'b1, 70);
		// source wider than the store reads background past the store edge
		run_setting(15'd8192, 16'd14189, 9'd511, 9'd1, 10'd700, 10'd700,
			32'hfedcba98, 1'b0, 50);
		for (int p = 0; p < 4; p++)
			run_setting(15'($urandom_range(0, 16384)), 16'($urandom_range(0, 32768) - 16384),
				9'($urandom_range(1, 12)), 9'($urandom_range(1, 12)),
				10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)),
				$urandom(), 1'($urandom_range(0, 1)), 30);

		wait_idle();
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
